/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the sorted priority table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* src/spt_pkg.sv */
// ----------------------------------------------------------------------------
// spt_pkg
// Types and constants of the sorted priority table.
// ----------------------------------------------------------------------------
package spt_pkg;

  localparam int DepthDefault   = 64;
  localparam int KeyBitsDefault = 16;

  typedef enum logic {
    ActInsert = 1'b0,
    ActRead   = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StFull   = 2'd1,
    StNoRank = 2'd2
  } status_e;

  typedef struct packed {
    action_e     action;
    logic [15:0] entry_key;
    logic [15:0] entry_handle;
    logic [5:0]  rank;
  } in_word_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] read_key;
    logic [15:0] read_handle;
    logic [6:0]  occupancy;
  } out_word_t;

  typedef struct packed {
    logic    load_item;
    logic    rd_at_tail;
    logic    rd_at_rank;
    logic    rd_next;
    logic    wr_shift;
    logic    wr_new_after;
    logic    wr_new_at0;
    logic    cnt_inc;
    logic    res_load;
    status_e res_status;
    logic    res_use_rd;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_read;
    logic full;
    logic empty;
    logic rank_ok;
    logic greater;
    logic ptr_zero;
  } ctl_sts_t;

endpackage

/* src/spt_datapath.sv */
// ----------------------------------------------------------------------------
// spt_datapath
// Entry memories, entry count, scan pointer and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spt_datapath #(
  parameter int DEPTH    = spt_pkg::DepthDefault,
  parameter int KEY_BITS = spt_pkg::KeyBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spt_pkg::in_word_t in_word_i,
  input  spt_pkg::ctl_cmd_t cmd_i,
  output spt_pkg::ctl_sts_t sts_o,
  output spt_pkg::out_word_t out_word_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > 6) ? CW : 6;

  logic [KEY_BITS-1:0] key_mem [DEPTH];
  logic [15:0]         hdl_mem [DEPTH];

  spt_pkg::in_word_t   item_q;
  spt_pkg::out_word_t  out_q, out_d;
  logic [CW-1:0]       count_q, count_d;
  logic [AW-1:0]       ptr_q, ptr_d;
  logic [KEY_BITS-1:0] key_rd_q;
  logic [15:0]         hdl_rd_q;

  logic [KEY_BITS-1:0] new_key;
  logic [AW-1:0]       tail;
  logic [XW-1:0]       rank_x;
  logic [XW-1:0]       count_x;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [KEY_BITS-1:0] wr_key;
  logic [15:0]         wr_hdl;

  assign new_key = KEY_BITS'(item_q.entry_key);
  assign tail    = AW'(count_q - 1'b1);
  assign rank_x  = XW'(item_q.rank);
  assign count_x = XW'(count_q);

  always_comb begin
    rd_en   = cmd_i.rd_at_tail | cmd_i.rd_at_rank | cmd_i.rd_next;
    rd_addr = ptr_q - 1'b1;
    ptr_d   = ptr_q;
    if (cmd_i.rd_at_tail) begin
      rd_addr = tail;
      ptr_d   = tail;
    end else if (cmd_i.rd_at_rank) begin
      rd_addr = AW'(rank_x);
    end else if (cmd_i.rd_next) begin
      ptr_d = ptr_q - 1'b1;
    end
  end

  always_comb begin
    wr_en   = cmd_i.wr_shift | cmd_i.wr_new_after | cmd_i.wr_new_at0;
    wr_addr = ptr_q + 1'b1;
    wr_key  = new_key;
    wr_hdl  = item_q.entry_handle;
    if (cmd_i.wr_shift) begin
      wr_key = key_rd_q;
      wr_hdl = hdl_rd_q;
    end else if (cmd_i.wr_new_at0) begin
      wr_addr = '0;
    end
  end

  assign count_d = cmd_i.cnt_inc ? count_q + 1'b1 : count_q;

  always_comb begin
    out_d = out_q;
    if (cmd_i.res_load) begin
      out_d.status      = cmd_i.res_status;
      out_d.read_key    = cmd_i.res_use_rd ? 16'(key_rd_q) : 16'd0;
      out_d.read_handle = cmd_i.res_use_rd ? hdl_rd_q : 16'd0;
      out_d.occupancy   = 7'(count_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      hdl_mem[wr_addr] <= wr_hdl;
    end
    if (rd_en) begin
      key_rd_q <= key_mem[rd_addr];
      hdl_rd_q <= hdl_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_word_i;
    end
    ptr_q <= ptr_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign sts_o.is_read  = (item_q.action == spt_pkg::ActRead);
  assign sts_o.full     = (count_q == CW'(DEPTH));
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.rank_ok  = (rank_x < count_x);
  assign sts_o.greater  = (key_rd_q > new_key);
  assign sts_o.ptr_zero = (ptr_q == '0);

  assign out_word_o = out_q;

  `ASSERT_ALWAYS(a_count_max, clk_i, rst_ni, count_q <= CW'(DEPTH), "count above depth")
  `ASSERT_NEXT(a_count_inc, clk_i, rst_ni, cmd_i.cnt_inc, count_q == $past(count_q) + 1'b1, "bad count step")
  `ASSERT_SAME(a_scan_ptr, clk_i, rst_ni, cmd_i.rd_next, ptr_q != '0, "scan below slot zero")

endmodule

/* src/spt_ctrl.sv */
// ----------------------------------------------------------------------------
// spt_ctrl
// Sequencer for insert scans, rank reads and result handoff.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  spt_pkg::ctl_sts_t sts_i,
  output spt_pkg::ctl_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DISPATCH = 6'b000010,
    S_SCAN     = 6'b000100,
    S_PLACE    = 6'b001000,
    S_RD_WAIT  = 6'b010000,
    S_OUT      = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts_i.is_read) begin
          if (sts_i.rank_ok) begin
            cmd_o.rd_at_rank = 1'b1;
            state_d          = S_RD_WAIT;
          end else begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = spt_pkg::StNoRank;
            state_d          = S_OUT;
          end
        end else if (sts_i.full) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = spt_pkg::StFull;
          state_d          = S_OUT;
        end else if (sts_i.empty) begin
          cmd_o.wr_new_at0 = 1'b1;
          cmd_o.cnt_inc    = 1'b1;
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = spt_pkg::StOk;
          state_d          = S_OUT;
        end else begin
          cmd_o.rd_at_tail = 1'b1;
          state_d          = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.greater) begin
          cmd_o.wr_shift = 1'b1;
          if (sts_i.ptr_zero) begin
            state_d = S_PLACE;
          end else begin
            cmd_o.rd_next = 1'b1;
          end
        end else begin
          cmd_o.wr_new_after = 1'b1;
          cmd_o.cnt_inc      = 1'b1;
          cmd_o.res_load     = 1'b1;
          cmd_o.res_status   = spt_pkg::StOk;
          state_d            = S_OUT;
        end
      end
      S_PLACE: begin
        cmd_o.wr_new_at0 = 1'b1;
        cmd_o.cnt_inc    = 1'b1;
        cmd_o.res_load   = 1'b1;
        cmd_o.res_status = spt_pkg::StOk;
        state_d          = S_OUT;
      end
      S_RD_WAIT: begin
        cmd_o.res_load   = 1'b1;
        cmd_o.res_status = spt_pkg::StOk;
        cmd_o.res_use_rd = 1'b1;
        state_d          = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  `ASSERT_NEXT(a_accept_dispatch, clk_i, rst_ni, in_valid_i && !in_stall_o, state_q == S_DISPATCH, "accept lost")
  `ASSERT_NEXT(a_result_out, clk_i, rst_ni, cmd_o.res_load, out_valid_o, "result not presented")
  `ASSERT_SAME(a_scan_state, clk_i, rst_ni, cmd_o.wr_shift, state_q == S_SCAN, "shift outside scan")

endmodule

/* src/sorted_priority_table_unit.sv */
// A read with a valid rank reads that entry, then loads the result; a read past the count,
// a refused insert or an insert into an empty table loads its result at dispatch; any other
// insert reads the tail, shifts each larger-keyed entry up one slot, then writes the new entry.
// One word at a time: the next word is accepted the cycle after the result is taken.
// Reset clears the entry count and control; the entry memories are not cleared.
// ----------------------------------------------------------------------------
// sorted_priority_table_unit
// Table of key and handle entries kept in ascending key order, with rank reads.
// ----------------------------------------------------------------------------
module sorted_priority_table_unit #(
  parameter int DEPTH    = spt_pkg::DepthDefault,
  parameter int KEY_BITS = spt_pkg::KeyBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  spt_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output spt_pkg::out_word_t out_word_o
);

  spt_pkg::ctl_cmd_t cmd;
  spt_pkg::ctl_sts_t sts;

  spt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  spt_datapath #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_word_o (out_word_o)
  );

endmodule
